// ===== hdl/blm_pkg.sv =====
// ----------------------------------------------------------------------------
// blm_pkg: shared types and constants for the battery level monitor
// Word types for both channels, register indexes, fixed-point constants
// and the request/response structs of the divider.
// ----------------------------------------------------------------------------
package blm_pkg;

    // Divider operand widths: percent numerator is up to 65535 * 100
    localparam int DIV_NUM_W = 23;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_CNT_W = 5;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_EMPTY_LEVEL = 2'd0;
    localparam logic [1:0] CFG_FULL_MV     = 2'd1;
    localparam logic [1:0] CFG_DIVIDER     = 2'd2;
    localparam logic [1:0] CFG_LOW_PERCENT = 2'd3;

    // Register reset values and fallbacks
    localparam logic [15:0] DEF_EMPTY_LEVEL = 16'd3200;
    localparam logic [15:0] DEF_FULL_MV     = 16'd4200;
    localparam logic [15:0] DEF_GAIN        = 16'd512;
    localparam logic [15:0] MIN_GAIN        = 16'd26;
    localparam logic [6:0]  DEF_LOW_PCT     = 7'd0;

    // EMA weights in Q0.16: alpha and one minus alpha
    localparam logic [31:0] ALPHA_Q16    = 32'd1966;
    localparam logic [15:0] EMA_KEEP_Q16 = 16'd63570;

    localparam logic [6:0]  PERCENT_FULL  = 7'd100;
    localparam logic [16:0] NOTIFY_DELTA  = 17'd20;

    typedef struct packed {
        logic [11:0] pin_mv;
        logic        read_ok;
    } t_in_word;

    typedef struct packed {
        logic [15:0] level_mv;
        logic [6:0]  charge_percent;
        logic        is_low;
        logic        notify;
    } t_out_word;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== hdl/blm_divider.sv =====
// ----------------------------------------------------------------------------
// blm_divider: restoring divider, one quotient bit per cycle
// Latches the operands on start and pulses done with the quotient after
// DIV_NUM_W iterations. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module blm_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  blm_pkg::t_div_req  i_req,
    output blm_pkg::t_div_rsp  o_rsp
);

    logic [blm_pkg::DIV_NUM_W-1:0] r_quo;
    logic [blm_pkg::DIV_DEN_W-1:0] r_rem;
    logic [blm_pkg::DIV_DEN_W-1:0] r_den;
    logic [blm_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [blm_pkg::DIV_DEN_W:0]   trial;
    logic                          fits;

    // Shift in the next dividend bit and try the subtract
    assign trial = {r_rem, r_quo[blm_pkg::DIV_NUM_W-1]};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= blm_pkg::DIV_CNT_W'(blm_pkg::DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - blm_pkg::DIV_CNT_W'(1);
                if (r_cnt == blm_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[blm_pkg::DIV_NUM_W-2:0], fits};
            r_rem <= fits ? blm_pkg::DIV_DEN_W'(trial - {1'b0, r_den})
                          : trial[blm_pkg::DIV_DEN_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== hdl/battery_level_monitor.sv =====
// ----------------------------------------------------------------------------
// battery_level_monitor: ADC sample averaging, EMA filter and charge status
// Sequence: a sample that does not close a reading gives no word and the next
//   sample may follow on the next cycle; a failed first sample goes straight
//   to S_EMIT; a closing sample passes S_MUL_GAIN, S_MUL_EMA, S_ADD_EMA (not
//   on the first reading), S_PCT and, when the percent needs a pass through
//   the 23-step divider, S_DIV_PCT; S_EMIT then loads its word for output.
// Stall: input stalls from a closing or failed first sample until its
//   word enters the output register, longer while that register is held.
// Reset: synchronous, active low; registers take their defaults, filter unprimed.
// ----------------------------------------------------------------------------
module battery_level_monitor #(
    parameter int SAMPLES_PER_READING = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input word channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  blm_pkg::t_in_word   i_in_word,
    // output word channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output blm_pkg::t_out_word  o_out_word,
    // configuration write port
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    // Average by reciprocal multiply: exact for 16-bit sums and up to 16 samples
    localparam int          AVG_SHIFT = 21;
    localparam logic [21:0] AVG_RECIP =
        22'((2 ** AVG_SHIFT + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING);

    // One-hot sequencer states
    typedef enum logic [6:0] {
        S_IDLE     = 7'b000_0001,
        S_MUL_GAIN = 7'b000_0010,
        S_MUL_EMA  = 7'b000_0100,
        S_ADD_EMA  = 7'b000_1000,
        S_PCT      = 7'b001_0000,
        S_DIV_PCT  = 7'b010_0000,
        S_EMIT     = 7'b100_0000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [15:0] r_empty_level, r_full_mv, r_gain;
    logic [6:0]  r_low_pct;

    // Accumulator and filter state
    logic [15:0] r_sum;
    logic [3:0]  r_idx;
    logic [31:0] r_filt;
    logic        r_primed;
    logic [15:0] r_last_mv;
    logic [6:0]  r_last_pct;
    logic        r_last_low;

    // Per-reading working registers
    logic        r_first;
    logic [15:0] r_avg;
    logic [15:0] r_pack;
    logic [47:0] r_prod;
    logic [15:0] r_mv;
    logic [6:0]  r_pct;

    // Output register
    logic                r_out_valid;
    blm_pkg::t_out_word  r_out_word;

    // Effective register values: zero or tiny settings fall back to defaults
    logic [15:0] eff_empty, eff_full, eff_gain;
    assign eff_empty = (r_empty_level == 16'd0) ? blm_pkg::DEF_EMPTY_LEVEL : r_empty_level;
    assign eff_full  = (r_full_mv == 16'd0) ? blm_pkg::DEF_FULL_MV : r_full_mv;
    assign eff_gain  = (r_gain < blm_pkg::MIN_GAIN) ? blm_pkg::DEF_GAIN : r_gain;

    logic        in_take, out_take, out_free;
    logic [15:0] sum_next;
    logic        last_sample;
    logic [36:0] avg_prod;
    logic [15:0] filt_mv;
    logic [31:0] gain_prod;
    logic        emit_low, emit_note;

    blm_pkg::t_div_req div_req;
    blm_pkg::t_div_rsp div_rsp;

    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign out_take = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Sum wraps at 16 bits; the reading closes on the last sample of the group
    assign sum_next    = r_sum + 16'(i_in_word.pin_mv);
    assign last_sample = ({1'b0, r_idx} + 5'd1) >= 5'(SAMPLES_PER_READING);
    assign avg_prod    = 37'(sum_next) * 37'(AVG_RECIP);
    assign filt_mv     = r_filt[31:16];
    assign gain_prod   = 32'(r_avg) * 32'(eff_gain);

    // Status for the word about to go out
    assign emit_low  = (r_pct <= r_low_pct);
    assign emit_note = r_first || (r_pct != r_last_pct) || (emit_low != r_last_low) ||
                       ({1'b0, r_last_mv} > ({1'b0, r_mv} + blm_pkg::NOTIFY_DELTA)) ||
                       ({1'b0, r_mv} > ({1'b0, r_last_mv} + blm_pkg::NOTIFY_DELTA));

    // Divider request: percent from S_PCT when the level is between the bounds
    always_comb begin
        div_req = '0;
        if ((r_state == S_PCT) && (filt_mv > eff_empty) && (filt_mv < eff_full)) begin
            div_req.start    = 1'b1;
            div_req.dividend = blm_pkg::DIV_NUM_W'(filt_mv - eff_empty) *
                               blm_pkg::DIV_NUM_W'(blm_pkg::PERCENT_FULL);
            div_req.divisor  = eff_full - eff_empty;
        end
    end

    blm_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (!i_in_word.read_ok) begin
                        if (!r_primed) begin
                            n_state = S_EMIT;
                        end
                    end else if (last_sample) begin
                        n_state = S_MUL_GAIN;
                    end
                end
            end
            S_MUL_GAIN: n_state = S_MUL_EMA;
            S_MUL_EMA: begin
                n_state = r_first ? S_PCT : S_ADD_EMA;
            end
            S_ADD_EMA: n_state = S_PCT;
            S_PCT: begin
                n_state = div_req.start ? S_DIV_PCT : S_EMIT;
            end
            S_DIV_PCT: begin
                if (div_rsp.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_empty_level <= blm_pkg::DEF_EMPTY_LEVEL;
            r_full_mv     <= blm_pkg::DEF_FULL_MV;
            r_gain        <= blm_pkg::DEF_GAIN;
            r_low_pct     <= blm_pkg::DEF_LOW_PCT;
            r_sum         <= '0;
            r_idx         <= '0;
            r_filt        <= '0;
            r_primed      <= 1'b0;
            r_last_mv     <= '0;
            r_last_pct    <= '0;
            r_last_low    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    blm_pkg::CFG_EMPTY_LEVEL: r_empty_level <= i_cfg_data;
                    blm_pkg::CFG_FULL_MV:     r_full_mv     <= i_cfg_data;
                    blm_pkg::CFG_DIVIDER:     r_gain        <= i_cfg_data;
                    blm_pkg::CFG_LOW_PERCENT: r_low_pct     <= i_cfg_data[6:0];
                    default: ;
                endcase
            end

            // Accumulate; drop the partial sum on a failed read
            if (in_take) begin
                if (!i_in_word.read_ok || last_sample) begin
                    r_sum <= '0;
                    r_idx <= '0;
                end else begin
                    r_sum <= sum_next;
                    r_idx <= r_idx + 4'd1;
                end
                // Seed the filter with the empty level on an early failure
                if (!i_in_word.read_ok && !r_primed) begin
                    r_filt <= {eff_empty, 16'd0};
                end
            end

            // Seed on the first reading, otherwise step the EMA
            if ((r_state == S_MUL_EMA) && r_first) begin
                r_filt <= {r_pack, 16'd0};
            end
            if (r_state == S_ADD_EMA) begin
                r_filt <= r_prod[47:16] + (32'(r_pack) * blm_pkg::ALPHA_Q16);
            end

            // Load a new word, or drop the one just taken
            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
                r_last_mv   <= r_mv;
                r_last_pct  <= r_pct;
                r_last_low  <= emit_low;
                r_primed    <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_first <= !r_primed;
            if (!i_in_word.read_ok) begin
                r_mv  <= eff_empty;
                r_pct <= '0;
            end else if (last_sample) begin
                r_avg <= avg_prod[36:21];
            end
        end
        // Q8.8 gain, floor, saturate to 16 bits
        if (r_state == S_MUL_GAIN) begin
            r_pack <= (gain_prod[31:24] != 8'd0) ? 16'hFFFF : gain_prod[23:8];
        end
        if ((r_state == S_MUL_EMA) && !r_first) begin
            r_prod <= 48'(r_filt) * 48'(blm_pkg::EMA_KEEP_Q16);
        end
        if (r_state == S_PCT) begin
            r_mv <= filt_mv;
            if (filt_mv <= eff_empty) begin
                r_pct <= '0;
            end else if (filt_mv >= eff_full) begin
                r_pct <= blm_pkg::PERCENT_FULL;
            end
        end
        if ((r_state == S_DIV_PCT) && div_rsp.done) begin
            r_pct <= div_rsp.quotient[6:0];
        end
        if ((r_state == S_EMIT) && out_free) begin
            r_out_word.level_mv       <= r_mv;
            r_out_word.charge_percent <= r_pct;
            r_out_word.is_low         <= emit_low;
            r_out_word.notify         <= emit_note;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
